/* rtl/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};   // -1

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // Recency update issued for one request; at most one bit is set.
    typedef struct packed {
        logic hit_touch;   // existing entry becomes most recent
        logic evict;       // least recent entry is replaced
        logic insert;      // next free slot is filled
    } lru_op_t;

endpackage

/* rtl/lkvc_tag_array.sv */
// Key store and parallel key compare for the LRU key-value cache.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_tag_array #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic [lkvc_pkg::KEY_W-1:0] lookup_key,
    input  logic [ENTRIES-1:0]         entry_valid,
    input  logic                       wr_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_idx,
    input  logic [lkvc_pkg::KEY_W-1:0] wr_key,
    output logic [ENTRIES-1:0]         hit_onehot,
    output logic                       hit,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_idx
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [lkvc_pkg::KEY_W-1:0] key_reg [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg[wr_idx] <= wr_key;
        end
    end

    // Valid keys are unique, so at most one lane matches.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_onehot[i] = entry_valid[i] && (key_reg[i] == lookup_key);
            hit_idx       = hit_idx | (IDX_W'(i) & {IDX_W{hit_onehot[i]}});
        end
    end

    assign hit = |hit_onehot;

endmodule

/* rtl/lkvc_lru.sv */
// Valid bits, recency ranks and occupancy of the LRU key-value cache.
// Depends on lkvc_pkg (lru_op_t).
`timescale 1ns / 1ps

module lkvc_lru #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lkvc_pkg::lru_op_t         op,
    input  logic [ENTRIES-1:0]        hit_onehot,
    output logic [ENTRIES-1:0]        entry_valid,
    output logic [$clog2(ENTRIES+1)-1:0] occupied,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] victim_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [IDX_W-1:0] rank_reg  [ENTRIES];
    logic [IDX_W-1:0] rank_next [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;

    logic [IDX_W-1:0]   lru_rank;
    logic [IDX_W-1:0]   hit_rank;
    logic [IDX_W-1:0]   old_rank;
    logic [ENTRIES-1:0] victim_onehot;
    logic [ENTRIES-1:0] free_onehot;
    logic [ENTRIES-1:0] target;

    // Ranks of valid entries always form 0..occupied-1, so the least
    // recent entry is the one holding rank occupied-1.
    assign lru_rank = IDX_W'(occ_reg - CNT_W'(1));

    // Entries are never freed, so they fill from index 0 upward.
    assign free_idx = IDX_W'(occ_reg);

    always_comb begin
        victim_idx = '0;
        hit_rank   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            victim_onehot[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            free_onehot[i]   = (occ_reg == CNT_W'(i));
            victim_idx       = victim_idx | (IDX_W'(i) & {IDX_W{victim_onehot[i]}});
            hit_rank         = hit_rank | (rank_reg[i] & {IDX_W{hit_onehot[i]}});
        end
    end

    always_comb begin
        target   = '0;
        old_rank = hit_rank;
        if (op.hit_touch) begin
            target = hit_onehot;
        end else if (op.evict) begin
            target   = victim_onehot;
            old_rank = lru_rank;
        end else if (op.insert) begin
            target = free_onehot;
        end
    end

    // An insert promotes a slot that was empty: every valid entry ages.
    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg + CNT_W'(op.insert);
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
            if (target[i]) begin
                rank_next[i]  = '0;
                valid_next[i] = 1'b1;
            end else if (valid_reg[i] && (op.insert || rank_reg[i] < old_rank)) begin
                rank_next[i] = rank_reg[i] + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (op.hit_touch || op.evict || op.insert) begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign entry_valid = valid_reg;
    assign occupied    = occ_reg;

endmodule

/* rtl/lru_key_value_cache_core.sv */
// Top level of the LRU key-value cache: request register, value memory,
// command decode and result register. Depends on lkvc_pkg, lkvc_tag_array
// and lkvc_lru.
// Throughput: one request per cycle unless m_ready stalls the result register;
// all keys compare and all ranks update at once, and the result is registered.
// Reset: clears valid bits, ranks, occupancy and handshake state, and sets
// capacity to 16; key and value stores are not cleared, so no clearing pass.
`timescale 1ns / 1ps

module lru_key_value_cache_core #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [lkvc_pkg::KEY_W-1:0]  s_key,
    input  logic [lkvc_pkg::DATA_W-1:0] s_value,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [lkvc_pkg::DATA_W-1:0] m_read_value,
    output logic                        m_evicted
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    // request register
    logic                        in_valid_reg;
    lkvc_pkg::cmd_t              in_cmd_reg;
    logic [lkvc_pkg::KEY_W-1:0]  in_key_reg;
    logic [lkvc_pkg::DATA_W-1:0] in_value_reg;

    // result register
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic                        out_evicted_reg;
    logic                        out_rd_sel_reg;
    logic [lkvc_pkg::DATA_W-1:0] rd_data_reg;

    logic [lkvc_pkg::CAP_W-1:0]  capacity_reg;

    logic [lkvc_pkg::DATA_W-1:0] value_mem [ENTRIES];

    logic                 fire;
    logic                 is_put;
    logic                 full;
    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     eff_cap;
    logic [ENTRIES-1:0]   hit_onehot;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [ENTRIES-1:0]   entry_valid;
    logic [CNT_W-1:0]     occupied;
    logic [IDX_W-1:0]     victim_idx;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     slot;
    lkvc_pkg::lru_op_t    op;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign is_put  = (in_cmd_reg == lkvc_pkg::CMD_PUT);

    // capacity of zero acts as one, above ENTRIES acts as ENTRIES
    assign cap_ext = CMP_W'(capacity_reg);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end
    assign full = (CMP_W'(occupied) >= eff_cap);

    always_comb begin
        op.hit_touch = fire && hit;
        op.evict     = fire && !hit && is_put && full;
        op.insert    = fire && !hit && is_put && !full;
    end

    always_comb begin
        if (hit) begin
            slot = hit_idx;
        end else if (full) begin
            slot = victim_idx;
        end else begin
            slot = free_idx;
        end
    end

    lkvc_tag_array #(
        .ENTRIES(ENTRIES)
    ) u_tags (
        .aclk        (aclk),
        .lookup_key  (in_key_reg),
        .entry_valid (entry_valid),
        .wr_en       (op.evict || op.insert),
        .wr_idx      (slot),
        .wr_key      (in_key_reg),
        .hit_onehot  (hit_onehot),
        .hit         (hit),
        .hit_idx     (hit_idx)
    );

    lkvc_lru #(
        .ENTRIES(ENTRIES)
    ) u_lru (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .hit_onehot  (hit_onehot),
        .entry_valid (entry_valid),
        .occupied    (occupied),
        .victim_idx  (victim_idx),
        .free_idx    (free_idx)
    );

    // every put writes its value: hit, eviction or fresh slot
    always_ff @(posedge aclk) begin
        if (fire && is_put) begin
            value_mem[slot] <= in_value_reg;
        end
        if (fire) begin
            rd_data_reg <= value_mem[hit_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg   <= lkvc_pkg::cmd_t'(s_command);
            in_key_reg   <= s_key;
            in_value_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_found_reg   <= hit;
            out_evicted_reg <= op.evict;
            out_rd_sel_reg  <= hit && !is_put;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_found      = out_found_reg;
    assign m_evicted    = out_evicted_reg;
    assign m_read_value = out_rd_sel_reg ? rd_data_reg : lkvc_pkg::MISS_VALUE;

endmodule

/* test/tb_lru_key_value_cache_core.sv */
// Self-checking testbench for lru_key_value_cache_core: directed table, then random
// get/put traffic under several capacities and stall patterns, checked by an LRU predictor.
// Depends on lkvc_pkg and the rtl of lru_key_value_cache_core.
`timescale 1ns / 1ps

module tb_lru_key_value_cache_core;

    localparam int ENTRIES     = lkvc_pkg::ENTRIES_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic                        found;
        logic [lkvc_pkg::DATA_W-1:0] read_value;
        logic                        evicted;
    } cache_result_t;

    typedef struct packed {
        lkvc_pkg::cmd_t              cmd;
        logic [lkvc_pkg::KEY_W-1:0]  key;
        logic [lkvc_pkg::DATA_W-1:0] val;
        logic                        known;     // expected result typed into the table
        cache_result_t               want;
    } stim_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_command;
    logic [lkvc_pkg::KEY_W-1:0]  s_key;
    logic [lkvc_pkg::DATA_W-1:0] s_value;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_found;
    logic [lkvc_pkg::DATA_W-1:0] m_read_value;
    logic                        m_evicted;

    // predictor state
    logic [lkvc_pkg::KEY_W-1:0]  key_mem [ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] val_mem [ENTRIES];
    logic                        live    [ENTRIES];
    int unsigned                 rank_of [ENTRIES];
    int unsigned                 occupancy;
    logic [lkvc_pkg::CAP_W-1:0]  cap_reg;

    cache_result_t               pending_results[$];
    stim_row_t                   directed_rows[$];
    logic [lkvc_pkg::KEY_W-1:0]  key_pool[32];

    logic                        row_known;
    cache_result_t               row_want;
    int                          snd_idle_pct;
    int                          rcv_idle_pct;
    int                          hold_asked;
    int                          hold_served;
    int                          fail_count;
    int                          stall_cycles;

    lru_key_value_cache_core #(.ENTRIES(ENTRIES)) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_read_value (m_read_value),
        .m_evicted    (m_evicted)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // LRU predictor
    // ------------------------------------------------------------------
    function automatic void make_most_recent(int s);
        int unsigned old_rank;
        old_rank = live[s] ? rank_of[s] : ENTRIES;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != s && live[i] && rank_of[i] < old_rank)
                rank_of[i]++;
        end
        rank_of[s] = 0;
    endfunction

    function automatic cache_result_t lru_predict(lkvc_pkg::cmd_t cmd,
                                                  logic [lkvc_pkg::KEY_W-1:0] key,
                                                  logic [lkvc_pkg::DATA_W-1:0] val);
        cache_result_t r;
        int            hit;
        int            slot;
        int unsigned   worst;
        int unsigned   lim;
        r.found      = 1'b0;
        r.read_value = lkvc_pkg::MISS_VALUE;
        r.evicted    = 1'b0;
        hit          = -1;
        slot         = -1;
        worst        = 0;
        lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && live[i] && key_mem[i] == key)
                hit = i;
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            if (cmd == lkvc_pkg::CMD_GET)
                r.read_value = val_mem[hit];
            else
                val_mem[hit] = val;
            make_most_recent(hit);
        end else if (cmd == lkvc_pkg::CMD_PUT) begin
            // full (or capacity lowered below occupancy): replace the oldest entry only
            if (occupancy >= lim) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (live[i] && (slot < 0 || rank_of[i] > worst)) begin
                        slot  = i;
                        worst = rank_of[i];
                    end
                end
                if (slot >= 0)
                    r.evicted = 1'b1;
            end
            if (slot < 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && !live[i])
                        slot = i;
                end
                if (slot >= 0)
                    occupancy++;
            end
            if (slot >= 0) begin
                make_most_recent(slot);
                live[slot]    = 1'b1;
                key_mem[slot] = key;
                val_mem[slot] = val;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on request, compare on response, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cache_result_t got;
        cache_result_t pred;
        cache_result_t want;
        if (aresetn) begin
            if (cfg_wr_en)
                cap_reg = cfg_wr_data;
            if (s_valid && s_ready) begin
                pred = lru_predict(lkvc_pkg::cmd_t'(s_command), s_key, s_value);
                pending_results.push_back(row_known ? row_want : pred);
            end
            if (m_valid && m_ready) begin
                got.found      = m_found;
                got.read_value = m_read_value;
                got.evicted    = m_evicted;
                if (pending_results.size() == 0) begin
                    $error("response with no request pending: %s=%0b %s=%h %s=%0b",
                           "found", got.found, "read_value", got.read_value,
                           "evicted", got.evicted);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, got.found);
                        fail_count++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               want.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0b, actual %0b", want.evicted, got.evicted);
                        fail_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("lru_key_value_cache_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side: random back-pressure plus one long hold on demand
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_served++;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic offer_request(input lkvc_pkg::cmd_t cmd,
                                 input logic [lkvc_pkg::KEY_W-1:0] key,
                                 input logic [lkvc_pkg::DATA_W-1:0] val, input logic known,
                                 input cache_result_t want);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        s_value   <= val;
        row_known <= known;
        row_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait for every outstanding response
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // keys mostly from a small pool so hits and evictions are frequent
    task automatic run_random(input int count, input int span, input int pause_at);
        cache_result_t              none;
        lkvc_pkg::cmd_t             cmd;
        logic [lkvc_pkg::KEY_W-1:0] key;
        none = '0;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at)
                drain();
            if ($urandom_range(99) < 12)
                key = $urandom;
            else
                key = key_pool[$urandom_range(span - 1)];
            cmd = ($urandom_range(99) < 45) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET;
            offer_request(cmd, key, $urandom, 1'b0, none);
        end
    endtask

    function automatic stim_row_t mk_row(lkvc_pkg::cmd_t c, logic [lkvc_pkg::KEY_W-1:0] k,
                                         logic [lkvc_pkg::DATA_W-1:0] v,
                                         logic known, logic f,
                                         logic [lkvc_pkg::DATA_W-1:0] rd, logic ev);
        stim_row_t r;
        r.cmd             = c;
        r.key             = k;
        r.val             = v;
        r.known           = known;
        r.want.found      = f;
        r.want.read_value = rd;
        r.want.evicted    = ev;
        return r;
    endfunction

    initial begin
        int c;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_command    = 1'b0;
        s_key        = '0;
        s_value      = '0;
        row_known    = 1'b0;
        row_want     = '0;
        snd_idle_pct = 15;
        rcv_idle_pct = 54;
        hold_asked   = 0;
        hold_served  = 0;
        fail_count   = 0;
        stall_cycles = 0;
        cap_reg      = lkvc_pkg::CAP_RESET;
        occupancy    = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            key_mem[i] = '0;
            val_mem[i] = '0;
            live[i]    = 1'b0;
            rank_of[i] = 0;
        end
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;

        // directed table, run at capacity 2
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0,
                                       1'b1, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000,
                                       1'b1, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF,
                                       1'b1, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0,
                                       1'b1, 1'b1, 32'h8000_0000, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0,
                                       1'b1, 1'b0, lkvc_pkg::MISS_VALUE, 1'b1));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0,
                                       1'b1, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                       1'b1, 1'b1, lkvc_pkg::MISS_VALUE, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0,
                                       1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0,
                                       1'b1, 1'b1, 32'h0000_0000, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h5555_5555,
                                       1'b1, 1'b0, lkvc_pkg::MISS_VALUE, 1'b1));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'hAAAA_AAAA,
                                       1'b1, 1'b1, 32'h5555_5555, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0,
                                       1'b1, 1'b0, lkvc_pkg::MISS_VALUE, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h0000_0001, 32'h0000_0001,
                                       1'b0, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678,
                                       1'b0, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h0000_0002, 32'h0000_0002,
                                       1'b0, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h0000_0001, 32'h0,
                                       1'b0, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h0000_0001, 32'hAAAA_AAAA,
                                       1'b0, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h8000_0000,
                                       1'b0, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h0000_0002, 32'h0,
                                       1'b0, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(mk_row(lkvc_pkg::CMD_GET, 32'h0000_0001, 32'h0,
                                       1'b0, 1'b0, 32'h0, 1'b0));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_capacity(5'd2);
        foreach (directed_rows[i])
            offer_request(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].val,
                          directed_rows[i].known, directed_rows[i].want);
        drain();

        write_capacity(5'd16);
        run_random(400, 24, -1);
        drain();

        // capacity below current occupancy; receiver holds off to back up the pipe
        write_capacity(5'd3);
        hold_asked++;
        run_random(300, 6, -1);
        drain();

        snd_idle_pct = 54;
        rcv_idle_pct = 15;
        write_capacity(5'd0);
        run_random(250, 3, -1);
        drain();

        write_capacity(5'd31);
        run_random(400, 24, 200);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        c = $urandom_range(16, 1);
        write_capacity(lkvc_pkg::CAP_W'(c));
        run_random(350, c + 4, -1);
        drain();

        write_capacity(5'd1);
        run_random(250, 3, -1);
        drain();

        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("lru_key_value_cache_core regression: pass");
        else
            $display("lru_key_value_cache_core regression: fail");
        $finish;
    end

endmodule
